// ----- rtl/bfsa_pkg.sv -----
// package: sizes, request and status codes, controller/datapath command types
`timescale 1ns / 1ps
package bfsa_pkg;

    localparam int NUM_SLOTS   = 16;
    localparam int STORE_BYTES = 1024;
    localparam int HDR_LEN     = 1;

    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int LINK_W  = SLOT_W + 1;
    localparam int ADDR_W  = $clog2(STORE_BYTES);
    localparam int SIZE_W  = ADDR_W + 1;

    localparam int TYPE_W  = 3;
    localparam int LEN_W   = 10;
    localparam int ID_W    = 4;
    localparam int BADDR_W = 10;
    localparam int OFF_W   = 10;
    localparam int BYTE_W  = 8;
    localparam int STAT_W  = 3;
    localparam int CALC_W  = ((SIZE_W > OFF_W) ? SIZE_W : OFF_W) + 2;

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_SLOTS);

    localparam logic [TYPE_W-1:0] REQ_ALLOC     = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_FREE_SLOT = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_FREE_ADDR = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_READ      = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_WRITE     = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_LEN  = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_SLOT  = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_MEM   = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_SLOT = 3'd4;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd5;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
    localparam logic [OP_W-1:0] OP_CLEAR    = 4'd1;
    localparam logic [OP_W-1:0] OP_LATCH    = 4'd2;
    localparam logic [OP_W-1:0] OP_WALK     = 4'd3;
    localparam logic [OP_W-1:0] OP_COMMIT   = 4'd4;
    localparam logic [OP_W-1:0] OP_ADDR_RD  = 4'd5;
    localparam logic [OP_W-1:0] OP_SET_SLOT = 4'd6;
    localparam logic [OP_W-1:0] OP_HDR_RD   = 4'd7;
    localparam logic [OP_W-1:0] OP_UNLINK   = 4'd8;
    localparam logic [OP_W-1:0] OP_ACCESS   = 4'd9;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              resp;
        logic [STAT_W-1:0] status;
        logic              take_rd;
    } t_dp_cmd;

    typedef struct packed {
        logic              clr_done;
        logic [TYPE_W-1:0] req_type;
        logic              len_bad;
        logic              no_slot;
        logic              walk_end;
        logic              found;
        logic              addr_zero;
        logic              slot_ok;
        logic              addr_match;
        logic              range_bad;
        logic              unlink_done;
    } t_dp_status;

endpackage

// ----- rtl/bfsa_if.sv -----
// request and response channel interfaces
`timescale 1ns / 1ps
interface bfsa_req_if;
    logic                             valid;
    logic                             ready;
    logic [bfsa_pkg::TYPE_W-1:0]      req_type;
    logic [bfsa_pkg::LEN_W-1:0]       req_len;
    logic [bfsa_pkg::ID_W-1:0]        slot_id;
    logic [bfsa_pkg::BADDR_W-1:0]     byte_address;
    logic [bfsa_pkg::OFF_W-1:0]       byte_offset;
    logic [bfsa_pkg::BYTE_W-1:0]      write_data;

    modport source (output valid, req_type, req_len, slot_id, byte_address, byte_offset,
                    write_data, input ready);
    modport sink (input valid, req_type, req_len, slot_id, byte_address, byte_offset,
                  write_data, output ready);
endinterface

interface bfsa_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [bfsa_pkg::STAT_W-1:0]      status;
    logic [bfsa_pkg::ID_W-1:0]        alloc_slot;
    logic [bfsa_pkg::BADDR_W-1:0]     data_address;
    logic [bfsa_pkg::BYTE_W-1:0]      read_data;

    modport source (output valid, status, alloc_slot, data_address, read_data, input ready);
    modport sink (input valid, status, alloc_slot, data_address, read_data, output ready);
endinterface

// ----- rtl/bfsa_datapath.sv -----
// datapath: slot tables, address-ordered list walk, byte store and result registers
`timescale 1ns / 1ps
module bfsa_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bfsa_pkg::t_dp_cmd             i_cmd,
    output bfsa_pkg::t_dp_status          o_status,
    input  logic [bfsa_pkg::TYPE_W-1:0]   i_req_type,
    input  logic [bfsa_pkg::LEN_W-1:0]    i_req_len,
    input  logic [bfsa_pkg::ID_W-1:0]     i_slot_id,
    input  logic [bfsa_pkg::BADDR_W-1:0]  i_byte_address,
    input  logic [bfsa_pkg::OFF_W-1:0]    i_byte_offset,
    input  logic [bfsa_pkg::BYTE_W-1:0]   i_write_data,
    output logic [bfsa_pkg::STAT_W-1:0]   o_status_code,
    output logic [bfsa_pkg::ID_W-1:0]     o_alloc_slot,
    output logic [bfsa_pkg::BADDR_W-1:0]  o_data_address,
    output logic [bfsa_pkg::BYTE_W-1:0]   o_read_data
);
    // slot tables
    logic [bfsa_pkg::NUM_SLOTS-1:0] r_reserved;
    logic [bfsa_pkg::ADDR_W-1:0]    r_start [bfsa_pkg::NUM_SLOTS];
    logic [bfsa_pkg::SIZE_W-1:0]    r_size  [bfsa_pkg::NUM_SLOTS];
    logic [bfsa_pkg::LINK_W-1:0]    r_link  [bfsa_pkg::NUM_SLOTS];
    logic [bfsa_pkg::LINK_W-1:0]    r_head;
    logic [bfsa_pkg::ADDR_W-1:0]    r_clr_cnt;

    // byte store
    logic [bfsa_pkg::BYTE_W-1:0]    r_mem [bfsa_pkg::STORE_BYTES];
    logic [bfsa_pkg::BYTE_W-1:0]    r_rd;

    // request and walk registers
    logic [bfsa_pkg::TYPE_W-1:0]    r_req;
    logic [bfsa_pkg::LEN_W-1:0]     r_len;
    logic [bfsa_pkg::SIZE_W-1:0]    r_total;
    logic [bfsa_pkg::BADDR_W-1:0]   r_addr;
    logic [bfsa_pkg::OFF_W-1:0]     r_off;
    logic [bfsa_pkg::BYTE_W-1:0]    r_wdata;
    logic [bfsa_pkg::SLOT_W-1:0]    r_slot;
    logic                           r_sbad;
    logic                           r_noslot;
    logic [bfsa_pkg::LINK_W-1:0]    r_slink;
    logic [bfsa_pkg::LINK_W-1:0]    r_cur;
    logic [bfsa_pkg::LINK_W-1:0]    r_prev;
    logic [bfsa_pkg::SIZE_W-1:0]    r_pend;
    logic                           r_found;
    logic [bfsa_pkg::ADDR_W-1:0]    r_best_start;
    logic [bfsa_pkg::SIZE_W-1:0]    r_best_len;
    logic [bfsa_pkg::LINK_W-1:0]    r_best_prev;
    logic [bfsa_pkg::LINK_W-1:0]    r_best_next;

    // result registers
    logic [bfsa_pkg::STAT_W-1:0]    r_o_status;
    logic [bfsa_pkg::ID_W-1:0]      r_o_slot;
    logic [bfsa_pkg::BADDR_W-1:0]   r_o_addr;
    logic [bfsa_pkg::BYTE_W-1:0]    r_o_rd;

    logic [bfsa_pkg::SLOT_W-1:0]    cur_idx;
    logic                           at_end;
    logic [bfsa_pkg::ADDR_W-1:0]    cur_start;
    logic [bfsa_pkg::SIZE_W-1:0]    cur_size;
    logic [bfsa_pkg::LINK_W-1:0]    cur_link;
    logic [bfsa_pkg::SIZE_W-1:0]    hole_end;
    logic [bfsa_pkg::SIZE_W-1:0]    hole_len;
    logic                           take_hole;
    logic [bfsa_pkg::SLOT_W-1:0]    lowest_free;
    logic                           all_used;
    logic [bfsa_pkg::CALC_W-1:0]    acc_sum;
    logic [bfsa_pkg::ADDR_W-1:0]    acc_addr;
    logic                           unlink_hit;

    logic                           mem_we;
    logic [bfsa_pkg::ADDR_W-1:0]    mem_wa;
    logic [bfsa_pkg::BYTE_W-1:0]    mem_wd;
    logic                           mem_re;
    logic [bfsa_pkg::ADDR_W-1:0]    mem_ra;

    assign cur_idx   = r_cur[bfsa_pkg::SLOT_W-1:0];
    assign at_end    = (r_cur == bfsa_pkg::LINK_NONE);
    assign cur_start = r_start[cur_idx];
    assign cur_size  = r_size[cur_idx];
    assign cur_link  = r_link[cur_idx];

    // hole ahead of the current region, or the tail hole once the list ends
    assign hole_end  = at_end ? bfsa_pkg::SIZE_W'(bfsa_pkg::STORE_BYTES)
                              : bfsa_pkg::SIZE_W'(cur_start);
    assign hole_len  = (hole_end > r_pend) ? hole_end - r_pend : '0;
    assign take_hole = (hole_len >= r_total) && (!r_found || hole_len < r_best_len);

    always_comb begin
        lowest_free = '0;
        all_used    = 1'b1;
        for (int i = bfsa_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_reserved[i]) begin
                lowest_free = bfsa_pkg::SLOT_W'(i);
                all_used    = 1'b0;
            end
        end
    end

    assign acc_sum  = bfsa_pkg::CALC_W'(r_start[r_slot]) + bfsa_pkg::CALC_W'(bfsa_pkg::HDR_LEN)
                    + bfsa_pkg::CALC_W'(r_off);
    assign acc_addr = acc_sum[bfsa_pkg::ADDR_W-1:0];
    assign unlink_hit = !at_end && (cur_link == bfsa_pkg::LINK_W'(r_slot));

    always_comb begin
        o_status.clr_done    = (r_clr_cnt == bfsa_pkg::ADDR_W'(bfsa_pkg::STORE_BYTES - 1));
        o_status.req_type    = r_req;
        o_status.len_bad     = (r_len == '0) ||
                               (32'(r_len) > bfsa_pkg::STORE_BYTES - bfsa_pkg::HDR_LEN);
        o_status.no_slot     = r_noslot;
        o_status.walk_end    = at_end;
        o_status.found       = r_found;
        o_status.addr_zero   = (r_addr == '0) || (32'(r_addr) >= bfsa_pkg::STORE_BYTES);
        o_status.slot_ok     = !r_sbad && r_reserved[r_slot] &&
                               (r_rd == bfsa_pkg::BYTE_W'(r_slot));
        o_status.addr_match  = (bfsa_pkg::CALC_W'(r_start[r_slot])
                                + bfsa_pkg::CALC_W'(bfsa_pkg::HDR_LEN))
                               == bfsa_pkg::CALC_W'(r_addr);
        o_status.range_bad   = (bfsa_pkg::CALC_W'(r_off) + bfsa_pkg::CALC_W'(2)
                                > bfsa_pkg::CALC_W'(r_size[r_slot])) ||
                               (acc_sum >= bfsa_pkg::CALC_W'(bfsa_pkg::STORE_BYTES));
        o_status.unlink_done = (r_head == bfsa_pkg::LINK_W'(r_slot)) || at_end || unlink_hit;
    end

    // byte store port selection
    always_comb begin
        mem_we = 1'b0;
        mem_wa = acc_addr;
        mem_wd = r_wdata;
        mem_re = 1'b0;
        mem_ra = acc_addr;
        unique case (i_cmd.op)
            bfsa_pkg::OP_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr_cnt;
                mem_wd = '0;
            end
            bfsa_pkg::OP_COMMIT: begin
                mem_we = 1'b1;
                mem_wa = r_best_start;
                mem_wd = bfsa_pkg::BYTE_W'(r_slot);
            end
            bfsa_pkg::OP_ADDR_RD: begin
                mem_re = 1'b1;
                mem_ra = bfsa_pkg::ADDR_W'(r_addr - 1'b1);
            end
            bfsa_pkg::OP_HDR_RD: begin
                mem_re = 1'b1;
                mem_ra = r_start[r_slot];
            end
            bfsa_pkg::OP_ACCESS: begin
                mem_we = (r_req == bfsa_pkg::REQ_WRITE);
                mem_re = (r_req != bfsa_pkg::REQ_WRITE);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

    // control state: reservation bits, list head, links, clear counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved <= '0;
            r_head     <= bfsa_pkg::LINK_NONE;
            r_clr_cnt  <= '0;
            for (int i = 0; i < bfsa_pkg::NUM_SLOTS; i++) begin
                r_link[i] <= bfsa_pkg::LINK_NONE;
            end
        end else begin
            if (i_cmd.op == bfsa_pkg::OP_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.op == bfsa_pkg::OP_COMMIT) begin
                r_reserved[r_slot] <= 1'b1;
                r_link[r_slot]     <= r_best_next;
                if (r_best_prev != bfsa_pkg::LINK_NONE) begin
                    r_link[r_best_prev[bfsa_pkg::SLOT_W-1:0]] <= bfsa_pkg::LINK_W'(r_slot);
                end else begin
                    r_head <= bfsa_pkg::LINK_W'(r_slot);
                end
            end
            if (i_cmd.op == bfsa_pkg::OP_UNLINK) begin
                priority if (r_head == bfsa_pkg::LINK_W'(r_slot)) begin
                    r_head             <= r_slink;
                    r_reserved[r_slot] <= 1'b0;
                end else if (at_end) begin
                    r_reserved[r_slot] <= 1'b0;
                end else if (unlink_hit) begin
                    r_link[cur_idx]    <= r_slink;
                    r_reserved[r_slot] <= 1'b0;
                end
            end
        end
    end

    // request, walk and result registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            bfsa_pkg::OP_LATCH: begin
                r_req    <= i_req_type;
                r_len    <= i_req_len;
                r_total  <= bfsa_pkg::SIZE_W'(i_req_len)
                          + bfsa_pkg::SIZE_W'(bfsa_pkg::HDR_LEN);
                r_addr   <= i_byte_address;
                r_off    <= i_byte_offset;
                r_wdata  <= i_write_data;
                r_noslot <= all_used;
                if (i_req_type == bfsa_pkg::REQ_ALLOC) begin
                    r_slot <= lowest_free;
                    r_sbad <= 1'b0;
                end else begin
                    r_slot <= bfsa_pkg::SLOT_W'(i_slot_id);
                    r_sbad <= (32'(i_slot_id) >= bfsa_pkg::NUM_SLOTS);
                end
                r_cur    <= r_head;
                r_prev   <= bfsa_pkg::LINK_NONE;
                r_pend   <= '0;
                r_found  <= 1'b0;
                r_o_slot <= '0;
                r_o_addr <= '0;
                r_o_rd   <= '0;
            end
            bfsa_pkg::OP_WALK: begin
                if (take_hole) begin
                    r_found      <= 1'b1;
                    r_best_start <= r_pend[bfsa_pkg::ADDR_W-1:0];
                    r_best_len   <= hole_len;
                    r_best_prev  <= r_prev;
                    r_best_next  <= r_cur;
                end
                if (!at_end) begin
                    r_prev <= r_cur;
                    r_pend <= bfsa_pkg::SIZE_W'(cur_start) + cur_size;
                    r_cur  <= cur_link;
                end
            end
            bfsa_pkg::OP_COMMIT: begin
                r_start[r_slot] <= r_best_start;
                r_size[r_slot]  <= r_total;
                r_o_slot        <= bfsa_pkg::ID_W'(r_slot);
                r_o_addr        <= bfsa_pkg::BADDR_W'(bfsa_pkg::SIZE_W'(r_best_start)
                                   + bfsa_pkg::SIZE_W'(bfsa_pkg::HDR_LEN));
            end
            bfsa_pkg::OP_SET_SLOT: begin
                r_slot <= bfsa_pkg::SLOT_W'(r_rd);
                r_sbad <= (32'(r_rd) >= bfsa_pkg::NUM_SLOTS);
            end
            bfsa_pkg::OP_HDR_RD: begin
                r_slink <= r_link[r_slot];
                r_cur   <= r_head;
            end
            bfsa_pkg::OP_UNLINK: begin
                if (!at_end) begin
                    r_cur <= cur_link;
                end
            end
            default: begin
                r_found <= r_found;
            end
        endcase
        if (i_cmd.resp) begin
            r_o_status <= i_cmd.status;
            if (i_cmd.take_rd) begin
                r_o_rd <= r_rd;
            end
        end
    end

    assign o_status_code  = r_o_status;
    assign o_alloc_slot   = r_o_slot;
    assign o_data_address = r_o_addr;
    assign o_read_data    = r_o_rd;

endmodule

// ----- rtl/bfsa_ctrl.sv -----
// controller: request sequencing state machine
`timescale 1ns / 1ps
module bfsa_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    input  bfsa_pkg::t_dp_status  i_status,
    output bfsa_pkg::t_dp_cmd     o_cmd
);
    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DISP    = 4'd2;
    localparam logic [3:0] S_A_WALK  = 4'd3;
    localparam logic [3:0] S_A_FIN   = 4'd4;
    localparam logic [3:0] S_FA_SET  = 4'd5;
    localparam logic [3:0] S_H_RD    = 4'd6;
    localparam logic [3:0] S_H_CHK   = 4'd7;
    localparam logic [3:0] S_UNLINK  = 4'd8;
    localparam logic [3:0] S_R_WAIT  = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_DONE);

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = bfsa_pkg::OP_NONE;
        o_cmd.resp     = 1'b0;
        o_cmd.status   = bfsa_pkg::ST_OK;
        o_cmd.take_rd  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = bfsa_pkg::OP_CLEAR;
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.op = bfsa_pkg::OP_LATCH;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_status.req_type)
                    bfsa_pkg::REQ_ALLOC: begin
                        priority if (i_status.len_bad) begin
                            o_cmd.resp   = 1'b1;
                            o_cmd.status = bfsa_pkg::ST_BAD_LEN;
                            n_state      = S_DONE;
                        end else if (i_status.no_slot) begin
                            o_cmd.resp   = 1'b1;
                            o_cmd.status = bfsa_pkg::ST_NO_SLOT;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_A_WALK;
                        end
                    end
                    bfsa_pkg::REQ_FREE_SLOT, bfsa_pkg::REQ_READ, bfsa_pkg::REQ_WRITE: begin
                        n_state = S_H_RD;
                    end
                    bfsa_pkg::REQ_FREE_ADDR: begin
                        if (i_status.addr_zero) begin
                            o_cmd.resp   = 1'b1;
                            o_cmd.status = bfsa_pkg::ST_BAD_SLOT;
                            n_state      = S_DONE;
                        end else begin
                            o_cmd.op = bfsa_pkg::OP_ADDR_RD;
                            n_state  = S_FA_SET;
                        end
                    end
                    default: begin
                        // unknown request: plain ok
                        o_cmd.resp = 1'b1;
                        n_state    = S_DONE;
                    end
                endcase
            end
            S_A_WALK: begin
                o_cmd.op = bfsa_pkg::OP_WALK;
                if (i_status.walk_end) begin
                    n_state = S_A_FIN;
                end
            end
            S_A_FIN: begin
                o_cmd.resp = 1'b1;
                if (i_status.found) begin
                    o_cmd.op = bfsa_pkg::OP_COMMIT;
                end else begin
                    o_cmd.status = bfsa_pkg::ST_NO_MEM;
                end
                n_state = S_DONE;
            end
            S_FA_SET: begin
                o_cmd.op = bfsa_pkg::OP_SET_SLOT;
                n_state  = S_H_RD;
            end
            S_H_RD: begin
                o_cmd.op = bfsa_pkg::OP_HDR_RD;
                n_state  = S_H_CHK;
            end
            S_H_CHK: begin
                priority if (!i_status.slot_ok ||
                             (i_status.req_type == bfsa_pkg::REQ_FREE_ADDR &&
                              !i_status.addr_match)) begin
                    o_cmd.resp   = 1'b1;
                    o_cmd.status = bfsa_pkg::ST_BAD_SLOT;
                    n_state      = S_DONE;
                end else if (i_status.req_type == bfsa_pkg::REQ_FREE_SLOT ||
                             i_status.req_type == bfsa_pkg::REQ_FREE_ADDR) begin
                    n_state = S_UNLINK;
                end else if (i_status.range_bad) begin
                    o_cmd.resp   = 1'b1;
                    o_cmd.status = bfsa_pkg::ST_RANGE;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.op = bfsa_pkg::OP_ACCESS;
                    if (i_status.req_type == bfsa_pkg::REQ_WRITE) begin
                        o_cmd.resp = 1'b1;
                        n_state    = S_DONE;
                    end else begin
                        n_state = S_R_WAIT;
                    end
                end
            end
            S_UNLINK: begin
                o_cmd.op = bfsa_pkg::OP_UNLINK;
                if (i_status.unlink_done) begin
                    o_cmd.resp = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_R_WAIT: begin
                o_cmd.resp    = 1'b1;
                o_cmd.take_rd = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/best_fit_slot_allocator_unit.sv -----
// top level: best-fit slot allocator over a byte store
// allocate and free requests walk the address-ordered slot list one link per cycle, so their
// time grows with the number of reserved slots; read and write requests do not walk the list
// throughput: one request at a time, ready again the cycle after the response is taken
// reset: synchronous active low; after reset a clearing pass zeroes the byte store, ready low
`timescale 1ns / 1ps
module best_fit_slot_allocator_unit (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bfsa_req_if.sink   i_req,
    bfsa_rsp_if.source o_rsp
);
    bfsa_pkg::t_dp_cmd    cmd;
    bfsa_pkg::t_dp_status dp_status;

    bfsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_status    (dp_status),
        .o_cmd       (cmd)
    );

    bfsa_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (dp_status),
        .i_req_type     (i_req.req_type),
        .i_req_len      (i_req.req_len),
        .i_slot_id      (i_req.slot_id),
        .i_byte_address (i_req.byte_address),
        .i_byte_offset  (i_req.byte_offset),
        .i_write_data   (i_req.write_data),
        .o_status_code  (o_rsp.status),
        .o_alloc_slot   (o_rsp.alloc_slot),
        .o_data_address (o_rsp.data_address),
        .o_read_data    (o_rsp.read_data)
    );

endmodule

// ----- rtl/bfsa_checker.sv -----
// port checker for the allocator top level, with its bind
`timescale 1ns / 1ps
module bfsa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [bfsa_pkg::STAT_W-1:0]   i_status,
    input logic [bfsa_pkg::ID_W-1:0]     i_alloc_slot,
    input logic [bfsa_pkg::BADDR_W-1:0]  i_data_address,
    input logic [bfsa_pkg::BYTE_W-1:0]   i_read_data
);
    // one request in flight: never ready while a response waits
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req_ready && i_rsp_valid))
        else $error("request ready while response pending");

    // request taken drops ready next cycle
    a_ready_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("ready held after request");

    // failed requests carry zero payload
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_status != bfsa_pkg::ST_OK) |->
        (i_alloc_slot == '0 && i_data_address == '0 && i_read_data == '0))
        else $error("nonzero payload on failed response");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_status <= bfsa_pkg::ST_RANGE))
        else $error("undefined status code");

    // a stalled response holds still until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
        (i_rsp_valid && $stable(i_status) && $stable(i_alloc_slot) &&
         $stable(i_data_address) && $stable(i_read_data)))
        else $error("response changed while stalled");

endmodule

bind best_fit_slot_allocator_unit bfsa_checker u_bfsa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_alloc_slot   (o_rsp.alloc_slot),
    .i_data_address (o_rsp.data_address),
    .i_read_data    (o_rsp.read_data)
);
